// ----- rtl/gdft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdft_pkg
// Shared types, widths and codes of the depth-first traversal engine.
// ----------------------------------------------------------------------------
package gdft_pkg;

	// field widths
	localparam int MODE_W   = 2;
	localparam int VTX_W    = 5;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 6;
	// wide enough for any vertex number or count against the largest store
	localparam int CNT_W    = 7;

	// default store sizes
	localparam int DEF_MAX_VERTICES = 32;
	localparam int DEF_MAX_EDGES    = 64;

	// vertex count after reset
	localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;

	// request modes
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TRAV  = 2'd2;

	// result status codes
	localparam logic [STATUS_W-1:0] RES_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] RES_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] RES_FULL  = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [VTX_W-1:0]  from_vertex;
		logic [VTX_W-1:0]  to_vertex;
	} req_t;

	typedef struct packed {
		logic                valid;
		logic [VTX_W-1:0]    vertex;
		logic [STATUS_W-1:0] status;
		logic                last;
	} emit_t;

endpackage
`default_nettype wire

// ----- rtl/gdft_ifs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdft channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdft_in_if;
	logic                        valid;
	logic                        ready;
	logic [gdft_pkg::MODE_W-1:0] mode;
	logic [gdft_pkg::VTX_W-1:0]  from_vertex;
	logic [gdft_pkg::VTX_W-1:0]  to_vertex;

	modport source (output valid, mode, from_vertex, to_vertex, input ready);
	modport sink (input valid, mode, from_vertex, to_vertex, output ready);
endinterface

interface gdft_out_if;
	logic                          valid;
	logic                          ready;
	logic [gdft_pkg::VTX_W-1:0]    vertex;
	logic [gdft_pkg::STATUS_W-1:0] status;
	logic                          last;

	modport source (output valid, vertex, status, last, input ready);
	modport sink (input valid, vertex, status, last, output ready);
endinterface

interface gdft_cfg_if;
	logic                       valid;
	logic                       ready;
	logic [gdft_pkg::CFG_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/graph_depth_first_traversal_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// graph_depth_first_traversal_top
// Depth-first traversal engine over an adjacency-list edge store.
// Clear: result in the cycle after the request. Add edge: tail read, link
// write and, for a list that is not empty, back-link write to the old tail.
// Traverse: tries each start vertex in turn, reads the head of each vertex
// visited, reads each edge and checks its target, pops the stack at each
// list end; a result that waits on the output holds the walk.
// One request at a time; reset empties the store and sets vertex_count to 32.
// ----------------------------------------------------------------------------
module graph_depth_first_traversal_top #(
	parameter int MAX_VERTICES = gdft_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = gdft_pkg::DEF_MAX_EDGES
) (
	input logic        clk,
	input logic        arst_n,
	gdft_cfg_if.sink   cfg,
	gdft_in_if.sink    req,
	gdft_out_if.source rsp
);

	import gdft_pkg::*;

	logic [CFG_W-1:0]    vcount_q;
	logic [CNT_W-1:0]    vc7, n_eff;
	logic                rsp_valid_q;
	logic [VTX_W-1:0]    rsp_vertex_q;
	logic [STATUS_W-1:0] rsp_status_q;
	logic                rsp_last_q;
	logic                can_emit, seq_idle, start;
	req_t                req_s;
	emit_t               emit_s;

	// vertex count register
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q <= CFG_RESET;
		end else if (cfg.valid) begin
			vcount_q <= cfg.data;
		end
	end

	// effective count, saturated at the store size
	assign vc7   = CNT_W'(vcount_q);
	assign n_eff = (vc7 > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : vc7;

	// request side
	assign can_emit  = !rsp_valid_q || rsp.ready;
	assign req.ready = seq_idle && can_emit;
	assign start     = req.valid && req.ready;
	assign req_s     = '{mode: req.mode, from_vertex: req.from_vertex,
		to_vertex: req.to_vertex};

	gdft_seq #(
		.MAX_VERTICES (MAX_VERTICES),
		.MAX_EDGES    (MAX_EDGES)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.req      (req_s),
		.n_eff    (n_eff),
		.can_emit (can_emit),
		.idle     (seq_idle),
		.emit     (emit_s)
	);

	// result output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit_s.valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_s.valid) begin
			rsp_vertex_q <= emit_s.vertex;
			rsp_status_q <= emit_s.status;
			rsp_last_q   <= emit_s.last;
		end
	end

	assign rsp.valid  = rsp_valid_q;
	assign rsp.vertex = rsp_vertex_q;
	assign rsp.status = rsp_status_q;
	assign rsp.last   = rsp_last_q;

	// a new result never overwrites one still waiting
	assert property (@(posedge clk) disable iff (!arst_n)
		emit_s.valid |-> can_emit)
		else $error("result register overrun");

	// a clear request answers in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && req.mode == MODE_CLEAR) |=>
		(rsp.valid && rsp.last && rsp.status == RES_OK))
		else $error("clear result missing");

	// error results are always single and final
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != RES_OK) |-> rsp.last)
		else $error("error result without last");

	// no request is taken while a walk still has results to give
	assert property (@(posedge clk) disable iff (!arst_n)
		(emit_s.valid && !emit_s.last) |-> !req.ready)
		else $error("request taken during traversal");

endmodule
`default_nettype wire

// ----- rtl/gdft_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdft_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gdft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds while idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- rtl/gdft_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdft_seq
// Sequencer over the adjacency and stack memories: edge insertion, clearing
// and the stack-driven depth-first walk.
// ----------------------------------------------------------------------------
module gdft_seq #(
	parameter int MAX_VERTICES = gdft_pkg::DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = gdft_pkg::DEF_MAX_EDGES
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  gdft_pkg::req_t              req,
	input  logic [gdft_pkg::CNT_W-1:0]  n_eff,
	input  logic                        can_emit,
	output logic                        idle,
	output gdft_pkg::emit_t             emit
);

	import gdft_pkg::*;

	localparam int VAW = $clog2(MAX_VERTICES);
	localparam int CW  = $clog2(MAX_VERTICES + 1);
	localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam logic [EW-1:0] E_NULL = EW'(MAX_EDGES);
	localparam logic [CW-1:0] V_MAX  = CW'(MAX_VERTICES);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ADD_LINK = 4'd1;
	localparam logic [3:0] S_ADD_TAIL = 4'd2;
	localparam logic [3:0] S_SCAN     = 4'd3;
	localparam logic [3:0] S_HEAD     = 4'd4;
	localparam logic [3:0] S_EDGE     = 4'd5;
	localparam logic [3:0] S_POP      = 4'd6;
	localparam logic [3:0] S_ADV      = 4'd7;

	logic [3:0]              state_q;
	logic [MAX_VERTICES-1:0] lv_q;
	logic [MAX_VERTICES-1:0] vis_q;
	logic [EW-1:0]           used_q;
	logic [VAW-1:0]          from_q;
	logic [VTX_W-1:0]        to_q;
	logic                    tail_hit_q;
	logic                    hv_q;
	logic [CW-1:0]           s_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           depth_q;
	logic [EW-1:0]           top_c_q;

	// memory ports
	logic             head_we, head_re, tail_we, tail_re;
	logic [VAW-1:0]   head_waddr, head_raddr, tail_raddr;
	logic [EW-1:0]    head_rd, tail_rd;
	logic             tgt_we, tgt_re, nxt_we, nxt_re;
	logic [EAW-1:0]   tgt_waddr, nxt_waddr, edge_raddr;
	logic [VTX_W-1:0] tgt_rd;
	logic [EW-1:0]    nxt_wdata, nxt_rd;
	logic             stk_we, stk_re;
	logic [VAW-1:0]   stk_waddr, stk_raddr;
	logic [EW-1:0]    stk_rd;

	// decoded conditions
	logic [CNT_W-1:0] from7, to7, s7, t7;
	logic [VAW-1:0]   req_fidx, s_idx, t_idx;
	logic             req_bad, store_full;
	logic             scan_done, s_vis, t_new, top_null, push_ok, last_flag;
	logic             scan_hit, adv_hit;
	logic [CW-1:0]    depth_m1, depth_m2, cnt_p1;

	assign from7      = CNT_W'(req.from_vertex);
	assign to7        = CNT_W'(req.to_vertex);
	assign req_fidx   = from7[VAW-1:0];
	assign req_bad    = (from7 >= n_eff) || (to7 >= n_eff);
	assign store_full = (used_q == E_NULL);

	assign s7        = CNT_W'(s_q);
	assign s_idx     = s_q[VAW-1:0];
	assign scan_done = (s7 >= n_eff);
	assign s_vis     = vis_q[s_idx];
	assign scan_hit  = (state_q == S_SCAN) && !scan_done && !s_vis && can_emit;

	assign t7       = CNT_W'(tgt_rd);
	assign t_idx    = t7[VAW-1:0];
	assign t_new    = (t7 < n_eff) && !vis_q[t_idx];
	assign adv_hit  = (state_q == S_ADV) && t_new && can_emit;
	assign top_null = (top_c_q == E_NULL);
	assign push_ok  = (depth_q < V_MAX);

	assign depth_m1  = depth_q - CW'(1);
	assign depth_m2  = depth_q - CW'(2);
	assign cnt_p1    = cnt_q + CW'(1);
	assign last_flag = (CNT_W'(cnt_p1) == n_eff);

	assign idle = (state_q == S_IDLE);

	// memory control
	always_comb begin
		head_we    = (state_q == S_ADD_LINK) && !tail_hit_q;
		head_waddr = from_q;
		head_re    = scan_hit || (adv_hit && push_ok);
		head_raddr = (state_q == S_ADV) ? t_idx : s_idx;

		tail_we    = (state_q == S_ADD_LINK);
		tail_re    = start && (req.mode == MODE_ADD) && !req_bad && !store_full;
		tail_raddr = req_fidx;

		tgt_we     = (state_q == S_ADD_LINK);
		tgt_waddr  = used_q[EAW-1:0];
		tgt_re     = (state_q == S_EDGE) && !top_null;
		nxt_re     = tgt_re;
		edge_raddr = top_c_q[EAW-1:0];

		nxt_we     = (state_q == S_ADD_LINK) || (state_q == S_ADD_TAIL);
		nxt_waddr  = (state_q == S_ADD_TAIL) ? tail_rd[EAW-1:0] : used_q[EAW-1:0];
		nxt_wdata  = (state_q == S_ADD_TAIL) ? used_q : E_NULL;

		stk_we     = adv_hit && push_ok;
		stk_waddr  = depth_m1[VAW-1:0];
		stk_re     = (state_q == S_EDGE) && top_null && (depth_q > CW'(1));
		stk_raddr  = depth_m2[VAW-1:0];
	end

	// result generation
	always_comb begin
		emit = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					case (req.mode)
						MODE_CLEAR: begin
							emit.valid = 1'b1;
							emit.last  = 1'b1;
						end
						MODE_ADD: begin
							if (req_bad || store_full) begin
								emit.valid  = 1'b1;
								emit.last   = 1'b1;
								emit.status = req_bad ? RES_RANGE : RES_FULL;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_ADD_LINK: begin
				emit.valid = !tail_hit_q;
				emit.last  = 1'b1;
			end
			S_ADD_TAIL: begin
				emit.valid = 1'b1;
				emit.last  = 1'b1;
			end
			S_SCAN: begin
				emit.valid  = scan_hit;
				emit.vertex = VTX_W'(s_q);
				emit.last   = last_flag;
			end
			S_ADV: begin
				emit.valid  = adv_hit;
				emit.vertex = tgt_rd;
				emit.last   = last_flag;
			end
			default: begin
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			lv_q       <= '0;
			vis_q      <= '0;
			used_q     <= '0;
			tail_hit_q <= 1'b0;
			hv_q       <= 1'b0;
			s_q        <= '0;
			cnt_q      <= '0;
			depth_q    <= '0;
			top_c_q    <= E_NULL;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						case (req.mode)
							MODE_CLEAR: begin
								lv_q   <= '0;
								used_q <= '0;
							end
							MODE_ADD: begin
								if (!req_bad && !store_full) begin
									tail_hit_q <= lv_q[req_fidx];
									state_q    <= S_ADD_LINK;
								end
							end
							MODE_TRAV: begin
								vis_q   <= '0;
								s_q     <= '0;
								cnt_q   <= '0;
								depth_q <= '0;
								state_q <= S_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				S_ADD_LINK: begin
					lv_q[from_q] <= 1'b1;
					if (tail_hit_q) begin
						state_q <= S_ADD_TAIL;
					end else begin
						used_q  <= used_q + EW'(1);
						state_q <= S_IDLE;
					end
				end
				S_ADD_TAIL: begin
					used_q  <= used_q + EW'(1);
					state_q <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_done) begin
						state_q <= S_IDLE;
					end else if (s_vis) begin
						s_q <= s_q + CW'(1);
					end else if (can_emit) begin
						vis_q[s_idx] <= 1'b1;
						cnt_q        <= cnt_p1;
						hv_q         <= lv_q[s_idx];
						depth_q      <= CW'(1);
						state_q      <= S_HEAD;
					end
				end
				S_HEAD: begin
					top_c_q <= hv_q ? head_rd : E_NULL;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					if (!top_null) begin
						state_q <= S_ADV;
					end else if (depth_q == CW'(1)) begin
						depth_q <= '0;
						s_q     <= s_q + CW'(1);
						state_q <= S_SCAN;
					end else begin
						depth_q <= depth_m1;
						state_q <= S_POP;
					end
				end
				S_POP: begin
					top_c_q <= stk_rd;
					state_q <= S_EDGE;
				end
				S_ADV: begin
					if (!t_new) begin
						top_c_q <= nxt_rd;
						state_q <= S_EDGE;
					end else if (can_emit) begin
						vis_q[t_idx] <= 1'b1;
						cnt_q        <= cnt_p1;
						if (push_ok) begin
							depth_q <= depth_q + CW'(1);
							hv_q    <= lv_q[t_idx];
							state_q <= S_HEAD;
						end else begin
							top_c_q <= nxt_rd;
							state_q <= S_EDGE;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload capture for edge insertion
	always_ff @(posedge clk) begin
		if (tail_re) begin
			from_q <= req_fidx;
			to_q   <= req.to_vertex;
		end
	end

	// list heads and tails per vertex
	gdft_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.waddr (head_waddr),
		.wdata (used_q),
		.re    (head_re),
		.raddr (head_raddr),
		.rdata (head_rd)
	);

	gdft_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_tail_ram (
		.clk   (clk),
		.we    (tail_we),
		.waddr (from_q),
		.wdata (used_q),
		.re    (tail_re),
		.raddr (tail_raddr),
		.rdata (tail_rd)
	);

	// edge slots: destination and link to the next slot
	gdft_ram #(.WIDTH(VTX_W), .DEPTH(MAX_EDGES)) u_tgt_ram (
		.clk   (clk),
		.we    (tgt_we),
		.waddr (tgt_waddr),
		.wdata (to_q),
		.re    (tgt_re),
		.raddr (edge_raddr),
		.rdata (tgt_rd)
	);

	gdft_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_nxt_ram (
		.clk   (clk),
		.we    (nxt_we),
		.waddr (nxt_waddr),
		.wdata (nxt_wdata),
		.re    (nxt_re),
		.raddr (edge_raddr),
		.rdata (nxt_rd)
	);

	// walk stack of edge cursors below the top entry
	gdft_ram #(.WIDTH(EW), .DEPTH(MAX_VERTICES)) u_stk_ram (
		.clk   (clk),
		.we    (stk_we),
		.waddr (stk_waddr),
		.wdata (nxt_rd),
		.re    (stk_re),
		.raddr (stk_raddr),
		.rdata (stk_rd)
	);

endmodule
`default_nettype wire
